>>> rtl/lgge_pkg.sv
// shared constants, types and codes of the life grid generation engine
package lgge_pkg;

    // grid geometry
    localparam int GridSize = 32;
    localparam int AddrW    = $clog2(GridSize);
    localparam int CntW     = $clog2(GridSize + 1);

    // stream widths
    localparam int InDataW  = 16;
    localparam int OutDataW = 8;
    localparam int ModeW    = 2;
    localparam int FieldW   = 5;

    // item modes
    localparam logic [ModeW-1:0] ModeWrite   = 2'd0;
    localparam logic [ModeW-1:0] ModeAdvance = 2'd1;
    localparam logic [ModeW-1:0] ModeRead    = 2'd2;

    typedef logic [GridSize-1:0] t_row;

    // one cycle of requests to the grid memory
    typedef struct packed {
        logic             rd_en;
        logic [AddrW-1:0] rd_addr;
        logic             wr_en;
        logic [AddrW-1:0] wr_addr;
        t_row             wr_data;
    } t_mem_req;

endpackage

>>> rtl/lgge_grid_mem.sv
// grid row memory with per-row valid bits standing in for the reset clear
module lgge_grid_mem (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lgge_pkg::t_mem_req i_req,
    output lgge_pkg::t_row    o_rd_data
);
    import lgge_pkg::*;

    t_row                r_mem [GridSize];
    t_row                r_rd_q;
    logic                r_rd_valid;
    logic [GridSize-1:0] r_valid;

    // storage write and registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        r_rd_q <= r_mem[i_req.rd_addr];
    end

    // valid bits: a row never written since reset reads as all dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
            r_rd_valid <= i_req.rd_en & r_valid[i_req.rd_addr];
        end
    end

    // no read issued or never written gives a dead row
    assign o_rd_data = r_rd_valid ? r_rd_q : '0;

endmodule

>>> rtl/lgge_row_rule.sv
// B3/S23 rule applied across one row from the rows above, here and below
module lgge_row_rule (
    input  lgge_pkg::t_row i_above,
    input  lgge_pkg::t_row i_here,
    input  lgge_pkg::t_row i_below,
    output lgge_pkg::t_row o_next
);
    import lgge_pkg::*;

    logic [GridSize+1:0] w_above;
    logic [GridSize+1:0] w_here;
    logic [GridSize+1:0] w_below;

    // dead cells beyond both borders
    assign w_above = {1'b0, i_above, 1'b0};
    assign w_here  = {1'b0, i_here, 1'b0};
    assign w_below = {1'b0, i_below, 1'b0};

    // neighbour count and rule per column
    always_comb begin
        logic [3:0] cnt;
        o_next = '0;
        for (int c = 0; c < GridSize; c++) begin
            cnt = 4'(w_above[c]) + 4'(w_above[c+1]) + 4'(w_above[c+2])
                + 4'(w_below[c]) + 4'(w_below[c+1]) + 4'(w_below[c+2])
                + 4'(w_here[c])  + 4'(w_here[c+2]);
            if (cnt == 4'd3) begin
                o_next[c] = 1'b1;
            end else if (cnt == 4'd2) begin
                o_next[c] = i_here[c];
            end else begin
                o_next[c] = 1'b0;
            end
        end
    end

endmodule

>>> rtl/life_grid_generation_engine_top.sv
// top level of the life grid generation engine: control, memory and rule
// A 32 x 32 grid of cells, all dead after reset, kept one row per word in a
// single-port-read, single-port-write memory. A write of one cell is a
// read-modify-write of its row and a read only reads the row; either item
// passes through the cell state and the final state before its result beat
// is offered, and the input is ready again once the result is in the output
// register. An advance walks the rows in order, reading one row ahead and
// writing the new row behind it while the previous generation's row above
// and current row sit in two registers, with one memory read per row.
// Cells beyond the border count as dead. Exactly one result beat follows
// each input beat; a finished result sits in an output register, so the next
// input beat can be taken while it waits.
module life_grid_generation_engine_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [lgge_pkg::InDataW-1:0]  s_axis_tdata,   // row[4:0], col[9:5], alive_in[10], zero fill
    input  logic [1:0]                    s_axis_tuser,   // mode[1:0]
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [lgge_pkg::OutDataW-1:0] m_axis_tdata,   // cell_value[0], zero fill
    output logic [1:0]                    m_axis_tuser    // echoed_mode[1:0]
);
    import lgge_pkg::*;

    // control states
    localparam logic [2:0] StIdle    = 3'd0;
    localparam logic [2:0] StCell    = 3'd1;
    localparam logic [2:0] StAdvLoad = 3'd2;
    localparam logic [2:0] StAdvRun  = 3'd3;
    localparam logic [2:0] StFin     = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [ModeW-1:0] r_mode, n_mode;
    logic [AddrW-1:0] r_idx, n_idx;
    logic [AddrW-1:0] r_col, n_col;
    logic             r_alive, n_alive;
    logic             r_inside, n_inside;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_res, n_res;
    t_row             r_above, n_above;
    t_row             r_here, n_here;
    logic             r_out_valid, n_out_valid;
    logic             r_out_val, n_out_val;
    logic [ModeW-1:0] r_out_mode, n_out_mode;

    t_mem_req         mem_req;
    t_row             rd_data;
    t_row             next_row;
    t_row             cell_row;

    logic             in_beat;
    logic [FieldW-1:0] in_row;
    logic [FieldW-1:0] in_col;

    assign in_row  = s_axis_tdata[4:0];
    assign in_col  = s_axis_tdata[9:5];
    assign in_beat = s_axis_tvalid & s_axis_tready;

    assign s_axis_tready = (r_state == StIdle);

    // grid memory
    lgge_grid_mem u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (mem_req),
        .o_rd_data(rd_data)
    );

    // next generation of the row held in r_here
    lgge_row_rule u_rule (
        .i_above(r_above),
        .i_here (r_here),
        .i_below(rd_data),
        .o_next (next_row)
    );

    // addressed cell replaced in the row just read
    always_comb begin
        cell_row        = rd_data;
        cell_row[r_col] = r_alive;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_col       = r_col;
        n_alive     = r_alive;
        n_inside    = r_inside;
        n_cnt       = r_cnt;
        n_res       = r_res;
        n_above     = r_above;
        n_here      = r_here;
        n_out_valid = r_out_valid & ~m_axis_tready;
        n_out_val   = r_out_val;
        n_out_mode  = r_out_mode;

        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = r_cnt[AddrW-1:0];
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = r_idx;
        mem_req.wr_data = (r_state == StCell) ? cell_row : next_row;

        case (r_state)
            StIdle: begin
                if (in_beat) begin
                    n_mode   = s_axis_tuser;
                    n_alive  = s_axis_tdata[10];
                    n_inside = (32'(in_row) < GridSize) && (32'(in_col) < GridSize);
                    n_col    = AddrW'(in_col);
                    n_res    = 1'b0;
                    if (s_axis_tuser == ModeAdvance) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = '0;
                        n_idx           = '0;
                        n_cnt           = CntW'(1);
                        n_above         = '0;
                        n_state         = StAdvLoad;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = AddrW'(in_row);
                        n_idx           = AddrW'(in_row);
                        n_state         = StCell;
                    end
                end
            end
            StCell: begin
                mem_req.wr_en = (r_mode == ModeWrite) && r_inside;
                n_res         = (r_mode == ModeRead) && r_inside && rd_data[r_col];
                n_state       = StFin;
            end
            StAdvLoad: begin
                // first row arrives, fetch the one below it
                n_here = rd_data;
                if (r_cnt < CntW'(GridSize)) begin
                    mem_req.rd_en = 1'b1;
                    n_cnt         = r_cnt + CntW'(1);
                end
                n_state = StAdvRun;
            end
            StAdvRun: begin
                // write the new row, slide the window down one row
                mem_req.wr_en = 1'b1;
                n_above       = r_here;
                n_here        = rd_data;
                n_idx         = r_idx + AddrW'(1);
                if (r_cnt < CntW'(GridSize)) begin
                    mem_req.rd_en = 1'b1;
                    n_cnt         = r_cnt + CntW'(1);
                end
                if (32'(r_idx) == GridSize - 1) begin
                    n_state = StFin;
                end
            end
            StFin: begin
                // hand the result to the output register once it is free
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_val   = r_res;
                    n_out_mode  = r_mode;
                    n_state     = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= StIdle;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_mode     <= n_mode;
        r_idx      <= n_idx;
        r_col      <= n_col;
        r_alive    <= n_alive;
        r_inside   <= n_inside;
        r_cnt      <= n_cnt;
        r_res      <= n_res;
        r_above    <= n_above;
        r_here     <= n_here;
        r_out_val  <= n_out_val;
        r_out_mode <= n_out_mode;
    end

    // result beat
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OutDataW-1){1'b0}}, r_out_val};
    assign m_axis_tuser  = r_out_mode;

`ifndef SYNTHESIS
    // the memory is written only while updating a cell or walking the rows
    a_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.wr_en |-> (r_state == StCell || r_state == StAdvRun))
        else $error("grid memory written outside a cell update or advance");

    // a held result is never overwritten: the sequencer waits in its final state
    a_fin_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StFin && r_out_valid && !m_axis_tready) |=> (r_state == StFin))
        else $error("result left final state while output register busy");

    // rows are rewritten strictly in order during an advance
    a_row_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == StAdvRun && $past(r_state) == StAdvRun)
            |-> (mem_req.wr_addr == $past(mem_req.wr_addr) + AddrW'(1)))
        else $error("advance skipped or repeated a row");
`endif

endmodule
